[rtl/core/ens_pkg.sv]
// Package for the Euclidean norm stream block.
// Holds the sequencer state type, configuration register indexes and result widths.
// No dependencies.
`default_nettype none

package ens_pkg;

  // Result width and the largest norm that can be reported.
  localparam int unsigned NORM_W   = 24;
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STRIDE_W   = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE       = 2'd1;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_ADD    = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_FINISH = 5'b10000
  } ens_state_t;

endpackage

`default_nettype wire

[rtl/core/euclidean_norm_stream.sv]
// Top level of the Euclidean norm stream block: sequencer, shared squarer,
// saturating accumulator and bit-serial square root. Depends on ens_pkg.
`default_nettype none

// Streams vector elements and returns floor(sqrt(sum of squares)) of the used
// elements on each element marked last, with a sticky overflow flag when the
// accumulator saturated. Elements at positions that are a multiple of the
// stride are used; complex mode adds the squares of both parts. One element
// is handled at a time and in_stall stays high while it is processed. A
// skipped element needs only the idle state; a used element passes through
// the multiply and add states for each part in turn, since the single
// squarer and the single saturating adder are used once per part. An element
// marked last then runs the square root, one result bit per cycle, and a
// finish state loads the output register; the finish state waits while an
// earlier result is still held by out_stall. The output register lets the
// next element be taken while a result waits.
module euclidean_norm_stream #(
  parameter int unsigned ELEMENT_WIDTH = 16,
  parameter int unsigned ACC_WIDTH     = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input element channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_real_part,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_imag_part,
  input  logic                              in_last,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ens_pkg::NORM_W-1:0]        out_norm,
  output logic                              out_overflow,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ens_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ens_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import ens_pkg::*;

  localparam int unsigned EW   = ELEMENT_WIDTH;
  localparam int unsigned PW   = 2 * EW;
  localparam int unsigned XW   = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam int unsigned RW   = (ACC_WIDTH + 1) / 2;
  localparam int unsigned NW   = 2 * RW;
  localparam int unsigned CW   = $clog2(RW + 1);
  localparam int unsigned MW   = (RW > NORM_W) ? RW : NORM_W;

  // Registers.
  ens_state_t              state_r, state_nxt;
  logic                    complex_r, complex_nxt;
  logic [STRIDE_W-1:0]     stride_r, stride_nxt;
  logic [STRIDE_W-1:0]     phase_r, phase_nxt;
  logic [ACC_WIDTH-1:0]    acc_r, acc_nxt;
  logic                    sat_r, sat_nxt;
  logic [EW-1:0]           re_mag_r, re_mag_nxt;
  logic [EW-1:0]           im_mag_r, im_mag_nxt;
  logic                    last_r, last_nxt;
  logic                    sel_im_r, sel_im_nxt;
  logic [PW-1:0]           prod_r, prod_nxt;
  logic [NW-1:0]           rad_r, rad_nxt;
  logic [RW+1:0]           rem_r, rem_nxt;
  logic [RW-1:0]           root_r, root_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [NORM_W-1:0]       out_norm_r, out_norm_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  // Combinational helpers.
  logic                    in_take;
  logic [EW-1:0]           re_raw, im_raw;
  logic [STRIDE_W-1:0]     eff_stride;
  logic [STRIDE_W:0]       phase_inc;
  logic                    used;
  logic [EW-1:0]           mul_op;
  logic [XW-1:0]           acc_sum;
  logic                    acc_over;
  logic [ACC_WIDTH-1:0]    acc_upd;
  logic [RW+1:0]           rem_shift;
  logic [RW+1:0]           trial;
  logic                    trial_ok;
  logic [MW-1:0]           root_wide;
  logic                    out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_norm     = out_norm_r;
  assign out_overflow = out_ovf_r;
  assign out_free     = !out_valid_r || !out_stall;

  // Magnitudes of the two's complement parts; the most negative value maps
  // to its exact unsigned magnitude.
  assign re_raw = in_real_part;
  assign im_raw = in_imag_part;

  // Stride phase: stride zero behaves as stride one.
  assign eff_stride = (stride_r == '0) ? STRIDE_W'(1) : stride_r;
  assign phase_inc  = {1'b0, phase_r} + (STRIDE_W + 1)'(1);
  assign used       = (phase_r == '0);

  // Shared squarer operand and saturating accumulator.
  assign mul_op   = sel_im_r ? im_mag_r : re_mag_r;
  assign acc_sum  = XW'(acc_r) + XW'(prod_r);
  assign acc_over = (acc_sum > XW'({ACC_WIDTH{1'b1}}));
  assign acc_upd  = acc_over ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];

  // One digit of the restoring square root.
  assign rem_shift = {rem_r[RW-1:0], rad_r[NW-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign trial_ok  = (rem_shift >= trial);

  // Norm saturates at the 24-bit limit when the root is wider.
  assign root_wide = MW'(root_r);

  always_comb begin
    state_nxt     = state_r;
    complex_nxt   = complex_r;
    stride_nxt    = stride_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    re_mag_nxt    = re_mag_r;
    im_mag_nxt    = im_mag_r;
    last_nxt      = last_r;
    sel_im_nxt    = sel_im_r;
    prod_nxt      = prod_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_norm_nxt  = out_norm_r;
    out_ovf_nxt   = out_ovf_r;

    // Configuration register writes.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COMPLEX_MODE: complex_nxt = cfg_data[0];
        CFG_STRIDE:       stride_nxt  = cfg_data[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end

    // A waiting result leaves once the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          re_mag_nxt = re_raw[EW-1] ? (~re_raw + EW'(1)) : re_raw;
          im_mag_nxt = im_raw[EW-1] ? (~im_raw + EW'(1)) : im_raw;
          last_nxt   = in_last;
          sel_im_nxt = 1'b0;
          if (phase_inc >= {1'b0, eff_stride}) begin
            phase_nxt = '0;
          end else begin
            phase_nxt = phase_inc[STRIDE_W-1:0];
          end
          if (used) begin
            state_nxt = ST_MUL;
          end else if (in_last) begin
            rad_nxt   = NW'(acc_r);
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = CW'(RW);
            state_nxt = ST_ROOT;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = PW'(mul_op) * PW'(mul_op);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        acc_nxt = acc_upd;
        if (acc_over) begin
          sat_nxt = 1'b1;
        end
        if (complex_r && !sel_im_r) begin
          sel_im_nxt = 1'b1;
          state_nxt  = ST_MUL;
        end else if (last_r) begin
          rad_nxt   = NW'(acc_upd);
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CW'(RW);
          state_nxt = ST_ROOT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROOT: begin
        rad_nxt = {rad_r[NW-3:0], 2'b00};
        if (trial_ok) begin
          rem_nxt  = rem_shift - trial;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_shift;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Load the result once the output register is free, then clear.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_norm_nxt  = (root_wide > MW'(NORM_MAX)) ? NORM_MAX : root_wide[NORM_W-1:0];
          out_ovf_nxt   = sat_r;
          acc_nxt       = '0;
          sat_nxt       = 1'b0;
          phase_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      complex_r   <= 1'b0;
      stride_r    <= STRIDE_W'(1);
      phase_r     <= '0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      complex_r   <= complex_nxt;
      stride_r    <= stride_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    re_mag_r   <= re_mag_nxt;
    im_mag_r   <= im_mag_nxt;
    last_r     <= last_nxt;
    sel_im_r   <= sel_im_nxt;
    prod_r     <= prod_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    cnt_r      <= cnt_nxt;
    out_norm_r <= out_norm_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

`default_nettype wire
